@@ sv/gcb_pkg.sv @@
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared constants, codes and types of the glyph column blitter.
// ----------------------------------------------------------------------------
package gcb_pkg;

   localparam int COLUMNS    = 256;
   localparam int PAGES      = 2;
   localparam int ROWS       = 32;
   localparam int BANDS      = 4;
   localparam int PAGE_BYTES = COLUMNS * BANDS;
   localparam int MEM_DEPTH  = PAGES * PAGE_BYTES;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);

   localparam logic [1:0] LAST_BAND = 2'(BANDS - 1);

   // Command codes of an input transaction.
   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PAGE_SELECT   = 3'd0;
   localparam logic [2:0] CSR_REVERSE_VIDEO = 3'd1;
   localparam logic [2:0] CSR_INSERT_CURSOR = 3'd2;
   localparam logic [2:0] CSR_DELETE_CURSOR = 3'd3;
   localparam logic [2:0] CSR_DIRECT_DRAW   = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LO,
      ST_HI
   } gcb_state_type;

   // Operands of one merge of a glyph byte into a buffer byte.
   typedef struct packed {
      logic [7:0] glyph;
      logic       invert;
      logic [3:0] limit;
      logic [2:0] offset;
      logic [7:0] old;
      logic       upper;
   } gcb_merge_req_type;

endpackage

@@ sv/gcb_merge_unit.sv @@
// ----------------------------------------------------------------------------
// gcb_merge_unit
// Shared merge unit: masks, inverts and shifts one glyph byte and merges
// either its lower or its upper half into an old buffer byte.
// ----------------------------------------------------------------------------
module gcb_merge_unit (
   input  gcb_pkg::gcb_merge_req_type req,
   output logic [7:0]                 merged
);
   import gcb_pkg::*;

   logic [7:0]  data;
   logic [7:0]  sel;
   logic [15:0] put;
   logic [15:0] keep;

   always_comb begin
      data = req.invert ? ~req.glyph : req.glyph;
      sel  = 8'hff >> (4'd8 - req.limit);
      put  = {8'h00, data & sel} << req.offset;
      keep = ~({8'h00, sel} << req.offset);
      if (req.upper) begin
         merged = (req.old & keep[15:8]) | put[15:8];
      end else begin
         merged = (req.old & keep[7:0]) | put[7:0];
      end
   end

endmodule

@@ sv/glyph_column_blit_page_lcd_core.sv @@
// ----------------------------------------------------------------------------
// glyph_column_blit_page_lcd_core
// A read transaction reads its buffer byte into a register, holds busy in
// ST_READ and gives its result from the result registers. A draw of n glyph
// bytes holds busy for one ST_LO state per byte and one ST_HI state per byte
// (none for the last when the row offset is zero or the last byte lands in the
// bottom band), one read-modify-write per buffer byte on one memory port pair
// and one shared merge unit; its results are registered and never stalled.
// The next transaction can be taken as soon as busy is low. After reset the
// block clears the frame buffer, one byte per cycle, with busy high.
// ----------------------------------------------------------------------------
module glyph_column_blit_page_lcd_core (
   input  logic        clock,
   input  logic        reset,
   // Input transactions.
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [7:0]  req_column,
   input  logic [4:0]  req_top_row,
   input  logic [5:0]  req_glyph_height,
   input  logic [2:0]  req_glyph_bytes,
   input  logic [7:0]  req_byte_zero,
   input  logic [7:0]  req_byte_one,
   input  logic [7:0]  req_byte_two,
   input  logic [7:0]  req_byte_three,
   input  logic        req_cursor_column,
   input  logic [9:0]  req_read_address,
   // Result transactions, one cycle each, no back-pressure.
   output logic        rsp_valid,
   output logic [9:0]  rsp_byte_address,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_last,
   // Configuration writes.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [0:0]  csr_wdata
);
   import gcb_pkg::*;

   // Sequencer state.
   gcb_state_type state_ff, state_in;

   // Configuration registers.
   logic page_ff, reverse_ff, insert_ff, delete_ff, direct_ff;

   // Clearing pass address.
   logic [MEM_AW-1:0] clr_addr_ff;

   // Context of the transaction in progress.
   logic [7:0]        col_ff;
   logic [1:0]        band_ff;
   logic [2:0]        offset_ff;
   logic [5:0]        remain_ff;
   logic [2:0]        idx_ff;
   logic [2:0]        cnt_ff;
   logic              invert_ff;
   logic              first_ff;
   logic [7:0]        glyph_ff [BANDS];
   logic [7:0]        carry_ff;
   logic [MEM_AW-1:0] base_ff;
   logic [9:0]        rd_local_ff;
   logic              oor_ff;

   // Result registers.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [9:0] rsp_addr_ff, rsp_addr_in;
   logic [7:0] rsp_value_ff, rsp_value_in;
   logic       rsp_last_ff, rsp_last_in;

   // Frame buffer memory.
   logic [7:0]        mem [MEM_DEPTH];
   logic [7:0]        mem_rdata_ff;
   logic [MEM_AW-1:0] mem_raddr;
   logic [MEM_AW-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_we;

   // Decode of an incoming transaction.
   logic              accept;
   logic [6:0]        h_sum;
   logic [6:0]        h_round;
   logic [2:0]        h_bands;
   logic [2:0]        nbytes;
   logic              draw_go;
   logic              read_oor;
   logic [MEM_AW-1:0] cur_base;
   logic [1:0]        band_next;

   // Shared merge unit.
   gcb_merge_req_type merge_req;
   logic [7:0]        merged;

   gcb_merge_unit u_merge (
      .req    (merge_req),
      .merged (merged)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_address = rsp_addr_ff;
   assign rsp_byte_value   = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

   // A draw is dropped when its column lies beyond the edge, its height is
   // zero, its glyph would cross the bottom row or no byte is drawn. The number
   // of bytes drawn is the smaller of the glyph's band count and the font's byte count.
   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      h_sum     = {2'b00, req_top_row} + {1'b0, req_glyph_height};
      h_round   = {1'b0, req_glyph_height} + 7'd7;
      h_bands   = h_round[5:3];
      nbytes    = (h_bands < req_glyph_bytes) ? h_bands : req_glyph_bytes;
      draw_go   = ({1'b0, req_column} < 9'(COLUMNS)) && (req_glyph_height != 6'd0) &&
                  (h_sum <= 7'(ROWS)) && (nbytes != 3'd0);
      read_oor  = ({1'b0, req_read_address} >= 11'(PAGE_BYTES));
      cur_base  = ((PAGES > 1) && page_ff) ? MEM_AW'(PAGE_BYTES) : '0;
      band_next = band_ff + 2'd1;
   end

   // Operands of the shared merge unit. The lower byte of a glyph byte uses
   // the freshly read buffer byte for the first band, and for later bands
   // the value left by the previous upper merge, which is already written.
   always_comb begin
      merge_req.glyph  = (idx_ff < 3'd4) ? glyph_ff[idx_ff[1:0]] : 8'h00;
      merge_req.invert = invert_ff;
      merge_req.limit  = (remain_ff >= 6'd8) ? 4'd8 : remain_ff[3:0];
      merge_req.offset = offset_ff;
      merge_req.upper  = (state_ff == ST_HI);
      if ((state_ff == ST_LO) && !first_ff) begin
         merge_req.old = carry_ff;
      end else begin
         merge_req.old = mem_rdata_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_READ) begin
                  state_in = ST_READ;
               end else if (draw_go) begin
                  state_in = ST_LO;
               end
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_LO: begin
            // The upper half goes to the next band unless this is the last
            // band, or the last glyph byte with no offset spills nothing.
            if ((band_ff != LAST_BAND) && !((cnt_ff == 3'd1) && (offset_ff == 3'd0))) begin
               state_in = ST_HI;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HI: begin
            state_in = (cnt_ff == 3'd1) ? ST_IDLE : ST_LO;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory access and result outputs.
   always_comb begin
      mem_raddr    = '0;
      mem_waddr    = '0;
      mem_wdata    = 8'h00;
      mem_we       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_addr_in  = {col_ff, band_ff};
      rsp_value_in = merged;
      rsp_last_in  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_waddr = clr_addr_ff;
            mem_we    = 1'b1;
         end
         ST_IDLE: begin
            if (req_command == CMD_READ) begin
               mem_raddr = cur_base + (read_oor ? '0 : MEM_AW'(req_read_address));
            end else begin
               mem_raddr = cur_base + MEM_AW'({req_column, req_top_row[4:3]});
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = rd_local_ff;
            rsp_value_in = oor_ff ? 8'h00 : mem_rdata_ff;
            rsp_last_in  = 1'b1;
         end
         ST_LO: begin
            mem_waddr    = base_ff + MEM_AW'({col_ff, band_ff});
            mem_wdata    = merged;
            mem_we       = 1'b1;
            mem_raddr    = base_ff + MEM_AW'({col_ff, band_next});
            rsp_valid_in = direct_ff;
            rsp_last_in  = (cnt_ff == 3'd1) &&
                           !((offset_ff != 3'd0) && (band_ff != LAST_BAND));
         end
         ST_HI: begin
            mem_waddr = base_ff + MEM_AW'({col_ff, band_next});
            mem_wdata = merged;
            mem_we    = 1'b1;
            // The spill byte below the last glyph byte is reported last.
            rsp_valid_in = direct_ff && (offset_ff != 3'd0) && (cnt_ff == 3'd1);
            rsp_addr_in  = {col_ff, band_next};
            rsp_last_in  = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Frame buffer: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      mem_rdata_ff <= mem[mem_raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         page_ff      <= 1'b0;
         reverse_ff   <= 1'b0;
         insert_ff    <= 1'b0;
         delete_ff    <= 1'b0;
         direct_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + MEM_AW'(1);
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_PAGE_SELECT:   page_ff    <= csr_wdata[0];
               CSR_REVERSE_VIDEO: reverse_ff <= csr_wdata[0];
               CSR_INSERT_CURSOR: insert_ff  <= csr_wdata[0];
               CSR_DELETE_CURSOR: delete_ff  <= csr_wdata[0];
               CSR_DIRECT_DRAW:   direct_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Transaction context and result payload.
   always_ff @(posedge clock) begin
      rsp_addr_ff  <= rsp_addr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (accept) begin
         col_ff      <= req_column;
         band_ff     <= req_top_row[4:3];
         offset_ff   <= req_top_row[2:0];
         remain_ff   <= req_glyph_height;
         idx_ff      <= req_glyph_bytes - 3'd1;
         cnt_ff      <= nbytes;
         invert_ff   <= reverse_ff ^ (insert_ff & req_cursor_column) ^ delete_ff;
         first_ff    <= 1'b1;
         glyph_ff[0] <= req_byte_zero;
         glyph_ff[1] <= req_byte_one;
         glyph_ff[2] <= req_byte_two;
         glyph_ff[3] <= req_byte_three;
         base_ff     <= cur_base;
         rd_local_ff <= req_read_address;
         oor_ff      <= read_oor;
      end else if (state_ff == ST_HI) begin
         // Step to the next glyph byte, one band further down.
         carry_ff  <= merged;
         band_ff   <= band_next;
         cnt_ff    <= cnt_ff - 3'd1;
         idx_ff    <= idx_ff - 3'd1;
         remain_ff <= remain_ff - 6'd8;
         first_ff  <= 1'b0;
      end
   end

endmodule

@@ sv/gcb_checker.sv @@
// ----------------------------------------------------------------------------
// gcb_checker
// Port-level checks of the glyph column blitter, bound to its top level.
// ----------------------------------------------------------------------------
module gcb_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_command,
   input logic [9:0] req_read_address,
   input logic       rsp_valid,
   input logic [9:0] rsp_byte_address,
   input logic       rsp_last
);
   import gcb_pkg::*;

   // The block is busy clearing its buffer right after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("block not busy after reset");

   // A read transaction answers with a last result that carries its own address.
   a_read_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_READ)) |=> ##1
      (rsp_valid && rsp_last && (rsp_byte_address == $past(req_read_address, 2))))
      else $error("read transaction gave no matching result");

   // More results of a transaction are pending, so the block stays busy.
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("block idle before its last result");

   // Results come only from work in progress.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result while idle");

   // A new transaction cannot produce a result the cycle after a last one.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result directly after a last result");

endmodule

bind glyph_column_blit_page_lcd_core gcb_checker u_gcb_checker (.*);

@@ tb/tb_glyph_column_blit_page_lcd_core.sv @@
// ----------------------------------------------------------------------------
// tb_glyph_column_blit_page_lcd_core
// Self-checking testbench for the glyph column blitter. It keeps its own copy
// of both frame buffer pages and of the five control bits, predicts the result
// bytes of every accepted draw and read transaction, and compares each result
// strobe field by field against the oldest prediction. Directed tests cover
// the edges of the glyph geometry, the inversions and page selection. Phases
// of random well-formed glyph columns, reads and malformed commands follow.
// ----------------------------------------------------------------------------
module tb_glyph_column_blit_page_lcd_core;
   timeunit 1ns;
   timeprecision 1ps;

   import gcb_pkg::*;

   // Cycles to let pass after the last expected result before the block is
   // taken as idle.
   localparam int SETTLE_CYCLES = 12;

   // One input transaction, with the fields as wide as the ports.
   // font[0] is byte_zero, font[3] is byte_three.
   typedef struct packed {
      logic            command;
      logic [7:0]      column;
      logic [4:0]      top_row;
      logic [5:0]      glyph_height;
      logic [2:0]      glyph_bytes;
      logic [3:0][7:0] font;
      logic            cursor_column;
      logic [9:0]      read_address;
   } glyph_req_type;

   // One result transaction as it should appear on the rsp_ ports.
   typedef struct packed {
      logic [9:0] byte_address;
      logic [7:0] byte_value;
      logic       last;
   } buffer_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_command = CMD_DRAW;
   logic [7:0] req_column = '0;
   logic [4:0] req_top_row = '0;
   logic [5:0] req_glyph_height = '0;
   logic [2:0] req_glyph_bytes = '0;
   logic [7:0] req_byte_zero = '0;
   logic [7:0] req_byte_one = '0;
   logic [7:0] req_byte_two = '0;
   logic [7:0] req_byte_three = '0;
   logic       req_cursor_column = 1'b0;
   logic [9:0] req_read_address = '0;
   logic       rsp_valid;
   logic [9:0] rsp_byte_address;
   logic [7:0] rsp_byte_value;
   logic       rsp_last;
   logic       csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [0:0] csr_wdata = '0;

   // Shadow of both frame buffer pages and of the control bits.
   logic [7:0] shadow_fb [MEM_DEPTH];
   bit cfg_page, cfg_reverse, cfg_insert, cfg_delete, cfg_direct;

   // Result bytes still owed by the block, oldest first.
   buffer_byte_type pending_bytes[$];

   // Recently drawn columns, so that reads land on bytes that hold pixels.
   int drawn_cols[$];

   bit idle_on = 1'b1;
   bit item_applied;
   int fail_count = 0;
   int draws_done = 0;
   int reads_done = 0;
   int bytes_checked = 0;
   int settings_count = 0;

   glyph_column_blit_page_lcd_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_column        (req_column),
      .req_top_row       (req_top_row),
      .req_glyph_height  (req_glyph_height),
      .req_glyph_bytes   (req_glyph_bytes),
      .req_byte_zero     (req_byte_zero),
      .req_byte_one      (req_byte_one),
      .req_byte_two      (req_byte_two),
      .req_byte_three    (req_byte_three),
      .req_cursor_column (req_cursor_column),
      .req_read_address  (req_read_address),
      .rsp_valid         (rsp_valid),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor. It applies one accepted transaction to the shadow buffer and
   // queues the result bytes that the block has to produce for it. It returns
   // 0 for a draw that the block drops, but 1 for one with no glyph bytes.
   // ------------------------------------------------------------------------
   function automatic bit predict_blit(glyph_req_type it);
      int base, col, top, h, gb, offset, band0, nbytes;
      int k, band, remain, limit, idx, a;
      logic [7:0] data, sel;
      logic [15:0] keep, put;
      buffer_byte_type burst[$];
      buffer_byte_type r;

      base = (int'(cfg_page) % PAGES) * PAGE_BYTES;

      // A read returns one byte of the selected page; addresses past the
      // page read as zero.
      if (it.command == CMD_READ) begin
         r.byte_address = it.read_address;
         r.byte_value   = (int'(it.read_address) < PAGE_BYTES) ?
                          shadow_fb[base + int'(it.read_address)] : 8'h00;
         r.last         = 1'b1;
         pending_bytes.push_back(r);
         reads_done++;
         return 1'b1;
      end

      col = it.column;
      top = it.top_row;
      h   = it.glyph_height;
      gb  = it.glyph_bytes;

      // A glyph that crosses the bottom, has no height, or lies past the
      // right edge is dropped.
      if (col >= COLUMNS || h == 0 || h > ROWS || top > ROWS - h)
         return 1'b0;

      offset = top % 8;
      band0  = top / 8;
      nbytes = (h + 7) / 8;
      if (nbytes > gb)
         nbytes = gb;

      for (k = 0; k < nbytes; k++) begin
         band = band0 + k;
         if (band >= BANDS)
            break;
         remain = h - 8 * k;
         limit  = (remain > 8) ? 8 : remain;
         // The last font byte lands in the top band; font indices above
         // three hold no pixels.
         idx  = gb - 1 - k;
         data = (idx < 4) ? it.font[idx] : 8'h00;
         // The keep mask follows the rows covered, before any inversion.
         sel  = 8'hff >> (8 - limit);
         keep = ~({8'h00, sel} << offset);
         if (cfg_reverse)
            data ^= 8'hff;
         if (cfg_insert && it.cursor_column)
            data ^= 8'hff;
         if (cfg_delete)
            data ^= 8'hff;
         put = {8'h00, data & sel} << offset;
         a = base + col * BANDS + band;
         shadow_fb[a] = (shadow_fb[a] & keep[7:0]) | put[7:0];
         if (band + 1 < BANDS)
            shadow_fb[a + 1] = (shadow_fb[a + 1] & keep[15:8]) | put[15:8];
         if (cfg_direct) begin
            r.byte_address = 10'(col * BANDS + band);
            r.byte_value   = shadow_fb[a];
            r.last         = 1'b0;
            burst.push_back(r);
         end
      end

      // With a row offset the band below the last drawn one also changed;
      // it is reported unless it would lie past the bottom band.
      if (cfg_direct && offset != 0 && nbytes > 0 && band0 + nbytes < BANDS) begin
         band = band0 + nbytes;
         r.byte_address = 10'(col * BANDS + band);
         r.byte_value   = shadow_fb[base + col * BANDS + band];
         r.last         = 1'b0;
         burst.push_back(r);
      end

      if (burst.size() > 0)
         burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i])
         pending_bytes.push_back(burst[i]);
      draws_done++;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Transaction builders.
   // ------------------------------------------------------------------------
   function automatic glyph_req_type draw_req(int column, int top_row, int height,
                                              int nbytes, logic [31:0] font,
                                              bit cursor);
      glyph_req_type it;
      it.command       = CMD_DRAW;
      it.column        = 8'(column);
      it.top_row       = 5'(top_row);
      it.glyph_height  = 6'(height);
      it.glyph_bytes   = 3'(nbytes);
      it.font          = font;
      it.cursor_column = cursor;
      it.read_address  = 10'($urandom_range(0, 1023));
      return it;
   endfunction

   function automatic glyph_req_type read_req(int addr);
      glyph_req_type it;
      it = draw_req($urandom_range(0, 255), $urandom_range(0, 31),
                    $urandom_range(0, 63), $urandom_range(0, 7), $urandom(),
                    1'($urandom_range(0, 1)));
      it.command      = CMD_READ;
      it.read_address = 10'(addr);
      return it;
   endfunction

   // A glyph column that fits on the display. Half of them land in a narrow
   // window of columns so that later glyphs merge into earlier pixels.
   function automatic glyph_req_type random_draw();
      int h, top, gb, col;
      h   = $urandom_range(1, 32);
      top = $urandom_range(0, 32 - h);
      gb  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : (h + 7) / 8;
      col = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(100, 107);
      drawn_cols.push_back(col);
      if (drawn_cols.size() > 16)
         void'(drawn_cols.pop_front());
      return draw_req(col, top, h, gb, $urandom(), 1'($urandom_range(0, 1)));
   endfunction

   function automatic glyph_req_type recent_read();
      int col;
      if (drawn_cols.size() == 0)
         return read_req($urandom_range(0, 1023));
      col = drawn_cols[$urandom_range(0, drawn_cols.size() - 1)];
      return read_req(col * BANDS + $urandom_range(0, BANDS - 1));
   endfunction

   // Anything at all: mostly heights past the bottom, which are dropped.
   function automatic glyph_req_type noise_req();
      glyph_req_type it;
      it = read_req($urandom_range(0, 1023));
      it.command = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Driving. Every task starts in the time step of a rising edge and leaves
   // in such a step. start is assigned at most once per step: send_item leaves
   // it high so that the next transaction can follow back to back.
   // ------------------------------------------------------------------------
   task automatic send_item(glyph_req_type it);
      start             <= 1'b1;
      req_command       <= it.command;
      req_column        <= it.column;
      req_top_row       <= it.top_row;
      req_glyph_height  <= it.glyph_height;
      req_glyph_bytes   <= it.glyph_bytes;
      req_byte_zero     <= it.font[0];
      req_byte_one      <= it.font[1];
      req_byte_two      <= it.font[2];
      req_byte_three    <= it.font[3];
      req_cursor_column <= it.cursor_column;
      req_read_address  <= it.read_address;
      // busy read here is the value the block saw at this edge.
      @(posedge clock);
      while (busy)
         @(posedge clock);
      item_applied = predict_blit(it);
   endtask

   // Random gap between transactions when idling is enabled.
   task automatic pace();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13))
            @(posedge clock);
      end
   endtask

   // Holds the sender off until every owed result has arrived and the block
   // has gone quiet. Draws without direct draw leave nothing to wait for, so
   // a settling wait passes before busy is looked at.
   task automatic drain();
      start <= 1'b0;
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, bit value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_PAGE_SELECT:   cfg_page    = value;
         CSR_REVERSE_VIDEO: cfg_reverse = value;
         CSR_INSERT_CURSOR: cfg_insert  = value;
         CSR_DELETE_CURSOR: cfg_delete  = value;
         CSR_DIRECT_DRAW:   cfg_direct  = value;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Writes all five control bits once the block is idle.
   task automatic apply_settings(bit page, bit reverse, bit insert, bit del, bit direct);
      drain();
      write_reg(CSR_PAGE_SELECT, page);
      write_reg(CSR_REVERSE_VIDEO, reverse);
      write_reg(CSR_INSERT_CURSOR, insert);
      write_reg(CSR_DELETE_CURSOR, del);
      write_reg(CSR_DIRECT_DRAW, direct);
      settings_count++;
   endtask

   // ------------------------------------------------------------------------
   // Result checker. Results cannot be held off, so every strobe is compared
   // at the edge that ends its cycle against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      buffer_byte_type want;
      if (!reset && rsp_valid) begin
         if (pending_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected result addr %0d value %02h last %0b",
                        $realtime, rsp_byte_address, rsp_byte_value, rsp_last);
         end else begin
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (rsp_byte_address !== want.byte_address ||
                rsp_byte_value !== want.byte_value || rsp_last !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"%0t: mismatch, expected addr %0d value %02h last %0b,",
                            " got addr %0d value %02h last %0b"},
                           $realtime, want.byte_address, want.byte_value, want.last,
                           rsp_byte_address, rsp_byte_value, rsp_last);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Full-height column, the bottom right pixel, a partial last byte with a
   // spill into the next band, a spill that would pass the bottom band, and
   // an aligned two-byte glyph; then read some of it back.
   task automatic test_basic_draws();
      apply_settings(0, 0, 0, 0, 1);
      send_item(draw_req(0, 0, 32, 4, 32'h3c_a5_00_ff, 0));
      send_item(draw_req(255, 31, 1, 1, 32'h00_00_00_ff, 0));
      send_item(draw_req(17, 3, 9, 2, 32'h00_00_c3_5a, 0));
      pace();
      send_item(draw_req(18, 28, 4, 1, 32'h00_00_00_f7, 0));
      send_item(draw_req(19, 8, 16, 2, 32'h00_00_81_7e, 1));
      send_item(read_req(0));
      send_item(read_req(3));
      send_item(read_req(1023));
      send_item(read_req(17 * BANDS + 1));
      send_item(read_req(17 * BANDS + 2));
   endtask

   // Glyphs that cross the bottom, have no height or no bytes, font indices
   // above three, and a single byte for a tall glyph.
   task automatic test_glyph_edges();
      send_item(draw_req(40, 20, 13, 2, $urandom(), 0));
      send_item(draw_req(41, 0, 33, 4, $urandom(), 0));
      send_item(draw_req(42, 5, 0, 1, $urandom(), 0));
      send_item(draw_req(43, 0, 63, 7, $urandom(), 1));
      send_item(draw_req(44, 0, 8, 0, $urandom(), 0));
      send_item(draw_req(20, 0, 16, 6, 32'hff_ff_ff_ff, 0));
      send_item(draw_req(21, 0, 32, 1, 32'h00_00_00_a5, 0));
      send_item(draw_req(22, 5, 24, 7, 32'h99_55_33_11, 0));
   endtask

   // Reverse video, the insert cursor with and without the cursor flag, and
   // reverse video, insert cursor and delete cursor all at once.
   task automatic test_inversions();
      apply_settings(0, 1, 0, 0, 1);
      send_item(draw_req(30, 2, 8, 1, 32'h00_00_00_0f, 0));
      apply_settings(0, 0, 1, 0, 1);
      send_item(draw_req(31, 4, 12, 2, 32'h00_00_3c_f0, 1));
      send_item(draw_req(32, 4, 12, 2, 32'h00_00_3c_f0, 0));
      apply_settings(0, 1, 1, 1, 1);
      send_item(draw_req(33, 9, 20, 3, 32'h00_12_34_56, 1));
   endtask

   // The second page starts blank and is separate from the first.
   task automatic test_pages();
      apply_settings(1, 0, 0, 0, 1);
      send_item(read_req(0));
      send_item(draw_req(0, 4, 12, 2, 32'h00_00_e7_18, 0));
      apply_settings(0, 0, 0, 0, 0);
      send_item(read_req(1));
   endtask

   // One phase of random traffic under the current settings. Draws dropped for
   // their geometry are not counted towards the number of transactions.
   task automatic run_random_phase(int items, bit idling);
      glyph_req_type it;
      int taken, pick, h;
      idle_on = idling;
      taken = 0;
      while (taken < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            it = random_draw();
         end else if (pick < 80) begin
            it = recent_read();
         end else if (pick < 88) begin
            it = read_req($urandom_range(0, 1023));
         end else if (pick < 94) begin
            // A glyph that reaches past the bottom row.
            h  = $urandom_range(2, 32);
            it = draw_req($urandom_range(0, 255), $urandom_range(33 - h, 31), h,
                          (h + 7) / 8, $urandom(), 1'($urandom_range(0, 1)));
         end else begin
            it = noise_req();
         end
         send_item(it);
         if (item_applied)
            taken++;
         // Now and then the sender waits for every result to come back.
         if ($urandom_range(0, 59) == 0)
            drain();
         else
            pace();
      end
   endtask

   // Several settings, the all-clear and all-set ones among them.
   task automatic test_random_settings();
      int phase;
      for (phase = 0; phase < 7; phase++) begin
         if (phase == 0)
            apply_settings(0, 0, 0, 0, 0);
         else if (phase == 1)
            apply_settings(1, 1, 1, 1, 1);
         else
            apply_settings($urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 1));
         run_random_phase(20, phase % 3 != 2);
      end
   endtask

   // Back-to-back traffic with direct draw on and no random idle gaps.
   task automatic test_back_to_back();
      apply_settings($urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1), 1);
      run_random_phase(20, 1'b0);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      foreach (shadow_fb[i])
         shadow_fb[i] = 8'h00;
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;
      // The block clears both pages after reset with busy high.
      drain();

      test_basic_draws();
      test_glyph_edges();
      test_inversions();
      test_pages();
      test_random_settings();
      test_back_to_back();

      drain();
      repeat (20)
         @(posedge clock);
      if (pending_bytes.size() != 0) begin
         fail_count += pending_bytes.size();
         $display("%0d result bytes never arrived", pending_bytes.size());
      end
      $display("Ran %0d glyph column draws and %0d buffer reads under %0d register settings,",
               draws_done, reads_done, settings_count);
      $display("checking %0d result bytes; %0d failures.", bytes_checked, fail_count);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("Watchdog expired with %0d result bytes outstanding", pending_bytes.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
sv/gcb_pkg.sv
sv/gcb_merge_unit.sv
sv/glyph_column_blit_page_lcd_core.sv
sv/gcb_checker.sv
tb/tb_glyph_column_blit_page_lcd_core.sv
